// ===== rtl/core/sfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sector frame reassembler.
// No dependencies.
package sfr_pkg;

  localparam int CNT_W    = 10;
  localparam int SEQ_W    = 4;
  localparam int SECF_W   = 16;
  localparam int IDX_W    = 13;
  localparam int SAMPLE_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX   = 10'd1023;
  localparam logic [CNT_W-1:0] MIN_BYTES = 10'd6;
  localparam logic [7:0]       SYNC_OUTER = 8'hFF;
  localparam logic [7:0]       SYNC_MID   = 8'h0F;
  localparam logic [7:0]       MARKER_HI  = 8'hFF;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_SAMPLE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    VD_ACCEPT    = 3'd0,
    VD_BAD_SYNC  = 3'd1,
    VD_TOO_SHORT = 3'd2,
    VD_MARKER    = 3'd3,
    VD_RANGE     = 3'd4,
    VD_LENGTH    = 3'd5
  } verdict_t;

  // Result fields other than the sample value, carried down the result pipe.
  typedef struct packed {
    kind_t                kind;
    verdict_t             verdict;
    logic [SEQ_W-1:0]     seq;
    logic [SECF_W-1:0]    sector;
    logic                 complete;
  } res_hdr_t;

endpackage

// ===== rtl/core/sector_frame_reassembler.sv =====
`timescale 1ns / 1ps
// Sector frame reassembler: checks frames, stores their samples by sector.
// Depends on sfr_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): with in_mode = byte, one frame byte per item,
//   in_frame_end marking the last byte of a frame; with in_mode = read, one sample
//   read at in_sample_index. Output channel (out_valid / out_stall): one verdict item
//   per frame end, one sample item per read, in the order of the inputs.
//   Frame bytes without frame_end give no result.
//   Throughput: one input item per cycle while in_stall is low. A result passes through
//   stage 1 (slot map read), stage 2 (sample memory read) and the output register on
//   its way to out_.
//   Samples are written straight into a spare slot of the sample memory as bytes
//   arrive; an accepted frame swaps that slot with the sector's slot, so a commit copies
//   no samples.
//   Reset: the frame parser restarts, the received mask clears and the slot map
//   returns to identity. Sample memory is not cleared; reading a never written
//   sample gives undefined data.
//   Receiver stall: out_ holds; the two pipe stages keep filling, and in_stall rises
//   only when both stages and the output register are full.
module sector_frame_reassembler #(
  parameter int SECTOR_COUNT = 16,
  parameter int FRAME_BYTES  = 730,
  parameter int HEADER_BYTES = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_frame_end,
  input  logic [sfr_pkg::IDX_W-1:0]     in_sample_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic [2:0]                    out_verdict,
  output logic [sfr_pkg::SEQ_W-1:0]     out_sequence_res,
  output logic [sfr_pkg::SECF_W-1:0]    out_sector,
  output logic                          out_complete,
  output logic [sfr_pkg::SAMPLE_W-1:0]  out_sample_value
);
  import sfr_pkg::*;

  localparam int SLOT_SAMPLES  = (FRAME_BYTES - HEADER_BYTES + 1) / 2;
  localparam int STORE_SAMPLES = SECTOR_COUNT * SLOT_SAMPLES;
  localparam int OFF_W   = (SLOT_SAMPLES > 1) ? $clog2(SLOT_SAMPLES) : 1;
  localparam int SLOT_W  = $clog2(SECTOR_COUNT + 1);
  localparam int SEC_W   = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
  localparam int ADDR_W  = SLOT_W + OFF_W;
  localparam int MEM_DEPTH = (SECTOR_COUNT + 1) * (2 ** OFF_W);
  localparam logic [OFF_W-1:0] LAST_IDX = OFF_W'(SLOT_SAMPLES - 1);
  // Odd payload length: a short final frame leaves the last sample unwritten.
  localparam logic LAST_FIX = ((FRAME_BYTES - HEADER_BYTES) % 2) == 1;

  // Handshake
  logic in_acc, byte_acc, rd_acc, end_acc, res_acc;
  logic o_ld, s2_free, s1_mv, s1_free;

  // Frame parser state
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              sync_r, sync_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [SECF_W-1:0] sec_r, sec_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic [SECTOR_COUNT-1:0] mask_r;
  logic [SEQ_W-1:0]  prev_seq_r;
  logic [SAMPLE_W-1:0] staging_last_r;

  logic              byte_we;
  logic [CNT_W-1:0]  off_b;
  logic [OFF_W-1:0]  wr_idx;
  logic [SAMPLE_W-1:0] wr_data;

  verdict_t          vd;
  logic              len_ok, commit_now, complete_now, fix_now, all_set;
  logic [SECTOR_COUNT-1:0] mask_base, mask_set;

  // Slot map and pending commit
  logic [SLOT_W-1:0] slot_map_r [SECTOR_COUNT];
  logic [SLOT_W-1:0] spare_r;
  logic [SLOT_W-1:0] map_rd_r;
  logic [SLOT_W-1:0] cmt_slot_r;
  logic              cmt_v_r;
  logic [SEC_W-1:0]  cmt_sec_r;
  logic              cmt_fix_r;
  logic              fix_we;

  // Read address split
  logic [SEC_W-1:0]  rd_sec;
  logic [IDX_W-1:0]  rd_base;
  logic [OFF_W-1:0]  rd_off;
  logic              rd_in_range, rd_fwd;

  // Sample memory
  logic [SAMPLE_W-1:0] sample_mem [MEM_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_mem_en;
  logic [ADDR_W-1:0]   s1_addr;

  // Result pipe
  logic              s1_v_r, s2_v_r, o_v_r;
  res_hdr_t          s1_hdr_r, s2_hdr_r, o_hdr_r, in_hdr;
  logic [OFF_W-1:0]  s1_off_r;
  logic              s1_fwd_r, s1_inr_r, s2_inr_r;
  logic [SLOT_W-1:0] s1_fwd_slot_r;
  logic [SAMPLE_W-1:0] o_sample_r;

  // ---------------------------------------------------------------- handshake
  assign o_ld    = s2_v_r && (!o_v_r || !out_stall);
  assign s2_free = !s2_v_r || o_ld;
  assign s1_mv   = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s1_mv;
  assign in_stall = !s1_free;

  assign in_acc   = in_valid && !in_stall;
  assign byte_acc = in_acc && (in_mode == MODE_BYTE);
  assign rd_acc   = in_acc && (in_mode == MODE_READ);
  assign end_acc  = byte_acc && in_frame_end;
  assign res_acc  = rd_acc || end_acc;

  // ---------------------------------------------------------------- frame parser
  always_comb begin
    sync_nxt = sync_r;
    seq_nxt  = seq_r;
    sec_nxt  = sec_r;
    hold_nxt = hold_r;
    case (cnt_r)
      CNT_W'(0): if (in_data_byte != SYNC_OUTER) sync_nxt = 1'b0;
      CNT_W'(1): if (in_data_byte != SYNC_MID)   sync_nxt = 1'b0;
      CNT_W'(2): if (in_data_byte != SYNC_OUTER) sync_nxt = 1'b0;
      CNT_W'(3): seq_nxt = in_data_byte[SEQ_W-1:0];
      CNT_W'(4): sec_nxt = {sec_r[15:8], in_data_byte};
      CNT_W'(5): sec_nxt = {in_data_byte, sec_r[7:0]};
      default: ;
    endcase
    byte_we = (cnt_r >= CNT_W'(HEADER_BYTES)) && (cnt_r < CNT_W'(FRAME_BYTES));
    off_b   = cnt_r - CNT_W'(HEADER_BYTES);
    wr_idx  = OFF_W'(off_b >> 1);
    wr_data = off_b[0] ? {in_data_byte, hold_r} : {8'h00, in_data_byte};
    if (byte_we && !off_b[0]) hold_nxt = in_data_byte;
    cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  end

  always_comb begin
    len_ok = (cnt_nxt == CNT_W'(FRAME_BYTES)) ||
             ((sec_nxt == SECF_W'(SECTOR_COUNT - 1)) && (cnt_nxt == CNT_W'(FRAME_BYTES - 1)));
    if (!sync_nxt)                            vd = VD_BAD_SYNC;
    else if (cnt_nxt < MIN_BYTES)             vd = VD_TOO_SHORT;
    else if (sec_nxt[15:8] == MARKER_HI)      vd = VD_MARKER;
    else if (sec_nxt >= SECF_W'(SECTOR_COUNT)) vd = VD_RANGE;
    else if (!len_ok)                         vd = VD_LENGTH;
    else                                      vd = VD_ACCEPT;

    commit_now   = end_acc && (vd == VD_ACCEPT);
    // A new sequence starts a fresh capture.
    mask_base    = (prev_seq_r != seq_nxt) ? '0 : mask_r;
    mask_set     = mask_base | (SECTOR_COUNT'(1) << sec_nxt[SEC_W-1:0]);
    all_set      = &mask_set;
    complete_now = commit_now && all_set;
    fix_now      = LAST_FIX && (cnt_nxt != CNT_W'(FRAME_BYTES));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sync_r     <= 1'b1;
      seq_r      <= '0;
      sec_r      <= '0;
      hold_r     <= '0;
      mask_r     <= '0;
      prev_seq_r <= '0;
    end else begin
      if (byte_acc) begin
        if (in_frame_end) begin
          cnt_r  <= '0;
          sync_r <= 1'b1;
          seq_r  <= '0;
          sec_r  <= '0;
          hold_r <= '0;
        end else begin
          cnt_r  <= cnt_nxt;
          sync_r <= sync_nxt;
          seq_r  <= seq_nxt;
          sec_r  <= sec_nxt;
          hold_r <= hold_nxt;
        end
      end
      if (commit_now) begin
        prev_seq_r <= seq_nxt;
        mask_r     <= all_set ? '0 : mask_set;
      end
    end
  end

  // Mirror of the last staging entry; it survives frames that do not write it.
  always_ff @(posedge clk) begin
    if (byte_acc && byte_we && (wr_idx == LAST_IDX)) staging_last_r <= wr_data;
  end

  // ---------------------------------------------------------------- slot map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SECTOR_COUNT; i++) slot_map_r[i] <= SLOT_W'(i);
      spare_r <= SLOT_W'(SECTOR_COUNT);
      cmt_v_r <= 1'b0;
    end else begin
      cmt_v_r <= commit_now;
      // Swap: the filled spare takes the sector, its old slot becomes spare.
      if (cmt_v_r) begin
        slot_map_r[cmt_sec_r] <= spare_r;
        spare_r               <= cmt_slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_acc) map_rd_r <= slot_map_r[rd_sec];
    if (commit_now) begin
      cmt_slot_r <= slot_map_r[sec_nxt[SEC_W-1:0]];
      cmt_sec_r  <= sec_nxt[SEC_W-1:0];
      cmt_fix_r  <= fix_now;
    end
  end

  // ---------------------------------------------------------------- read address
  always_comb begin
    rd_sec  = '0;
    rd_base = '0;
    for (int k = 1; k < SECTOR_COUNT; k++) begin
      if (in_sample_index >= IDX_W'(k * SLOT_SAMPLES)) begin
        rd_sec  = SEC_W'(k);
        rd_base = IDX_W'(k * SLOT_SAMPLES);
      end
    end
    rd_off      = OFF_W'(in_sample_index - rd_base);
    rd_in_range = in_sample_index < IDX_W'(STORE_SAMPLES);
    // A swap lands on this edge: take the slot it installs.
    rd_fwd      = cmt_v_r && (rd_sec == cmt_sec_r);
  end

  // ---------------------------------------------------------------- sample memory
  assign fix_we    = cmt_v_r && cmt_fix_r;
  assign rd_mem_en = s1_mv && (s1_hdr_r.kind == KIND_SAMPLE);
  assign s1_addr   = {(s1_fwd_r ? s1_fwd_slot_r : map_rd_r), s1_off_r};

  always_ff @(posedge clk) begin
    if (fix_we) begin
      sample_mem[{spare_r, LAST_IDX}] <= staging_last_r;
    end else if (byte_acc && byte_we) begin
      sample_mem[{spare_r, wr_idx}] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_mem_en) rd_data_r <= sample_mem[s1_addr];
  end

  // ---------------------------------------------------------------- result pipe
  always_comb begin
    in_hdr = '0;
    if (in_mode == MODE_READ) begin
      in_hdr.kind = KIND_SAMPLE;
    end else begin
      in_hdr.kind     = KIND_VERDICT;
      in_hdr.verdict  = vd;
      in_hdr.seq      = seq_nxt;
      in_hdr.sector   = sec_nxt;
      in_hdr.complete = complete_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (res_acc)    s1_v_r <= 1'b1;
      else if (s1_mv) s1_v_r <= 1'b0;
      if (s1_mv)      s2_v_r <= 1'b1;
      else if (o_ld)  s2_v_r <= 1'b0;
      if (o_ld)                       o_v_r <= 1'b1;
      else if (o_v_r && !out_stall)   o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_acc) begin
      s1_hdr_r      <= in_hdr;
      s1_off_r      <= rd_off;
      s1_fwd_r      <= rd_fwd;
      s1_fwd_slot_r <= spare_r;
      s1_inr_r      <= rd_in_range;
    end
    if (s1_mv) begin
      s2_hdr_r <= s1_hdr_r;
      s2_inr_r <= s1_inr_r;
    end
    if (o_ld) begin
      o_hdr_r    <= s2_hdr_r;
      o_sample_r <= ((s2_hdr_r.kind == KIND_SAMPLE) && s2_inr_r) ? rd_data_r : '0;
    end
  end

  assign out_valid        = o_v_r;
  assign out_result_kind  = o_hdr_r.kind;
  assign out_verdict      = o_hdr_r.verdict;
  assign out_sequence_res = o_hdr_r.seq;
  assign out_sector       = o_hdr_r.sector;
  assign out_complete     = o_hdr_r.complete;
  assign out_sample_value = o_sample_r;

  // ---------------------------------------------------------------- assertions
  a_commit_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    cmt_v_r |-> !commit_now)
    else $error("two commits on consecutive cycles");

  a_swap_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    cmt_v_r |-> (cmt_slot_r != spare_r))
    else $error("slot swap with the spare slot itself");

  a_fix_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    fix_we |-> !(byte_acc && byte_we))
    else $error("last sample write collides with a payload write");

  a_commit_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmt_v_r |-> (cnt_r == '0))
    else $error("swap lands after the next frame has started");

endmodule

// ===== dv/tb_sector_frame_reassembler.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sector_frame_reassembler: table-driven frames and reads,
// then random captures, against table results or an in-bench model of the parser, sector store and mask.
// Depends on sfr_pkg and the sector_frame_reassembler RTL.
module tb_sector_frame_reassembler;
  import sfr_pkg::*;

  localparam int SECTORS   = 16;
  localparam int FRAME_LEN = 730;
  localparam int HDR_LEN   = 6;
  localparam int SLOT_N    = (FRAME_LEN - HDR_LEN + 1) / 2;
  localparam int STORE_N   = SECTORS * SLOT_N;
  localparam logic [23:0] SYNC_WORD = {SYNC_OUTER, SYNC_MID, SYNC_OUTER};

  typedef struct packed {
    kind_t       kind;
    verdict_t    verdict;
    logic [3:0]  seq;
    logic [15:0] sector;
    logic        complete;
    logic [15:0] value;
  } res_t;

  typedef struct packed {
    mode_t       op;
    logic [12:0] idx;
    logic [23:0] sync;
    logic [7:0]  seq_b;
    logic [15:0] sec;
    logic [10:0] len;
    logic        fixed;
    res_t        want;
  } step_row_t;

  localparam res_t NO_RES = '0;

  localparam step_row_t STEPS [25] = '{
    '{MODE_READ, 13'd8191, 24'h0, 8'h00, 16'h0000, 11'd0, 1'b1,
      '{KIND_SAMPLE, VD_ACCEPT, 4'h0, 16'h0000, 1'b0, 16'h0000}},
    '{MODE_READ, 13'd5792, 24'h0, 8'h00, 16'h0000, 11'd0, 1'b1,
      '{KIND_SAMPLE, VD_ACCEPT, 4'h0, 16'h0000, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, 24'h000000, 8'h00, 16'h0000, 11'd1, 1'b1,
      '{KIND_VERDICT, VD_BAD_SYNC, 4'h0, 16'h0000, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h00, 16'h0000, 11'd1, 1'b1,
      '{KIND_VERDICT, VD_TOO_SHORT, 4'h0, 16'h0000, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h00, 16'h0000, 11'd3, 1'b1,
      '{KIND_VERDICT, VD_TOO_SHORT, 4'h0, 16'h0000, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h3A, 16'h0005, 11'd5, 1'b1,
      '{KIND_VERDICT, VD_TOO_SHORT, 4'hA, 16'h0005, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, 24'hFF0EFF, 8'h11, 16'h0004, 11'd730, 1'b1,
      '{KIND_VERDICT, VD_BAD_SYNC, 4'h1, 16'h0004, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, 24'hFF0F00, 8'h02, 16'h0001, 11'd6, 1'b1,
      '{KIND_VERDICT, VD_BAD_SYNC, 4'h2, 16'h0001, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h01, 16'hFF34, 11'd730, 1'b1,
      '{KIND_VERDICT, VD_MARKER, 4'h1, 16'hFF34, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'hFF, 16'hFFFF, 11'd6, 1'b1,
      '{KIND_VERDICT, VD_MARKER, 4'hF, 16'hFFFF, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h02, 16'h0010, 11'd730, 1'b1,
      '{KIND_VERDICT, VD_RANGE, 4'h2, 16'h0010, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h0E, 16'hFEFF, 11'd20, 1'b1,
      '{KIND_VERDICT, VD_RANGE, 4'hE, 16'hFEFF, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h03, 16'h0003, 11'd729, 1'b1,
      '{KIND_VERDICT, VD_LENGTH, 4'h3, 16'h0003, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h03, 16'h0003, 11'd731, 1'b1,
      '{KIND_VERDICT, VD_LENGTH, 4'h3, 16'h0003, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h04, 16'h0002, 11'd1100, 1'b1,
      '{KIND_VERDICT, VD_LENGTH, 4'h4, 16'h0002, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h04, 16'h000F, 11'd728, 1'b1,
      '{KIND_VERDICT, VD_LENGTH, 4'h4, 16'h000F, 1'b0, 16'h0000}},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'hF0, 16'h0000, 11'd730, 1'b1,
      '{KIND_VERDICT, VD_ACCEPT, 4'h0, 16'h0000, 1'b0, 16'h0000}},
    '{MODE_READ, 13'd0, 24'h0, 8'h00, 16'h0000, 11'd0, 1'b0, NO_RES},
    '{MODE_READ, 13'd361, 24'h0, 8'h00, 16'h0000, 11'd0, 1'b0, NO_RES},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h00, 16'h000F, 11'd729, 1'b1,
      '{KIND_VERDICT, VD_ACCEPT, 4'h0, 16'h000F, 1'b0, 16'h0000}},
    '{MODE_READ, 13'd5791, 24'h0, 8'h00, 16'h0000, 11'd0, 1'b0, NO_RES},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h05, 16'h0007, 11'd730, 1'b1,
      '{KIND_VERDICT, VD_ACCEPT, 4'h5, 16'h0007, 1'b0, 16'h0000}},
    '{MODE_READ, 13'd2534, 24'h0, 8'h00, 16'h0000, 11'd0, 1'b0, NO_RES},
    '{MODE_BYTE, 13'd0, SYNC_WORD, 8'h05, 16'h000F, 11'd730, 1'b1,
      '{KIND_VERDICT, VD_ACCEPT, 4'h5, 16'h000F, 1'b0, 16'h0000}},
    '{MODE_READ, 13'd5791, 24'h0, 8'h00, 16'h0000, 11'd0, 1'b0, NO_RES}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = MODE_BYTE;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_frame_end = 1'b0;
  logic [12:0] in_sample_index = 13'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [2:0]  out_verdict;
  logic [3:0]  out_sequence_res;
  logic [15:0] out_sector;
  logic        out_complete;
  logic [15:0] out_sample_value;

  // Table rows carry a hand-written result alongside the item that produces it.
  logic        table_fixed = 1'b0;
  res_t        table_res = '0;

  // Model state: frame parser, staging, sample store, received mask.
  logic [9:0]         frm_len = '0;
  logic               frm_sync = 1'b1;
  logic [3:0]         frm_seq = '0;
  logic [15:0]        frm_sector = '0;
  logic [7:0]         lo_byte = '0;
  logic [15:0]        stage_buf [SLOT_N];
  logic [15:0]        sample_mem [STORE_N];
  logic [SECTORS-1:0] rx_mask = '0;
  logic [3:0]         last_seq = '0;

  res_t pending_results [$];
  int   n_errors = 0;
  int   n_sent = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   read_mix_pct = 0;
  bit   sector_loaded [SECTORS];
  int   n_loaded = 0;
  bit   cap_left [SECTORS];
  int   n_left = 0;
  logic [3:0] cap_seq = '0;

  sector_frame_reassembler #(
    .SECTOR_COUNT(SECTORS),
    .FRAME_BYTES (FRAME_LEN),
    .HEADER_BYTES(HDR_LEN)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_data_byte    (in_data_byte),
    .in_frame_end    (in_frame_end),
    .in_sample_index (in_sample_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_verdict     (out_verdict),
    .out_sequence_res(out_sequence_res),
    .out_sector      (out_sector),
    .out_complete    (out_complete),
    .out_sample_value(out_sample_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Advance the model by one item; returns 1 when the item yields a result.
  function automatic logic reassemble(input mode_t m, input logic [7:0] b, input logic fe,
                                      input logic [12:0] idx, output res_t r);
    int pos;
    int off;
    r = '0;
    if (m == MODE_READ) begin
      r.kind = KIND_SAMPLE;
      r.value = (idx < STORE_N) ? sample_mem[idx] : 16'h0000;
      return 1'b1;
    end
    pos = int'(frm_len);
    case (pos)
      0: if (b != SYNC_OUTER) frm_sync = 1'b0;
      1: if (b != SYNC_MID) frm_sync = 1'b0;
      2: if (b != SYNC_OUTER) frm_sync = 1'b0;
      3: frm_seq = b[3:0];
      4: frm_sector[7:0] = b;
      5: frm_sector[15:8] = b;
      default: ;
    endcase
    // Bytes past the full frame are not staged.
    if (pos >= HDR_LEN && pos < FRAME_LEN) begin
      off = pos - HDR_LEN;
      if (off % 2 == 0) begin
        lo_byte = b;
        stage_buf[off / 2] = {8'h00, b};
      end else begin
        stage_buf[off / 2] = {b, lo_byte};
      end
    end
    if (frm_len != CNT_MAX) frm_len++;
    if (!fe) return 1'b0;

    r.kind = KIND_VERDICT;
    r.seq = frm_seq;
    r.sector = frm_sector;
    if (!frm_sync) r.verdict = VD_BAD_SYNC;
    else if (frm_len < MIN_BYTES) r.verdict = VD_TOO_SHORT;
    else if (frm_sector[15:8] == MARKER_HI) r.verdict = VD_MARKER;
    else if (frm_sector >= SECTORS) r.verdict = VD_RANGE;
    else if (frm_len != FRAME_LEN &&
             !(frm_sector == SECTORS - 1 && frm_len == FRAME_LEN - 1)) r.verdict = VD_LENGTH;
    else r.verdict = VD_ACCEPT;

    if (r.verdict == VD_ACCEPT) begin
      // Short final sector: the missing high byte reads as zero.
      if (frm_len < FRAME_LEN && (FRAME_LEN - HDR_LEN) % 2 == 0)
        stage_buf[SLOT_N-1][15:8] = 8'h00;
      if (last_seq != frm_seq) rx_mask = '0;
      last_seq = frm_seq;
      for (int i = 0; i < SLOT_N; i++)
        sample_mem[int'(frm_sector) * SLOT_N + i] = stage_buf[i];
      rx_mask[frm_sector[3:0]] = 1'b1;
      if (&rx_mask) begin
        r.complete = 1'b1;
        rx_mask = '0;
      end
    end
    frm_len = '0;
    frm_sync = 1'b1;
    frm_seq = '0;
    frm_sector = '0;
    lo_byte = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : track_and_check
    res_t r;
    res_t want;
    if (rst_n && in_valid && !in_stall) begin
      if (reassemble(mode_t'(in_mode), in_data_byte, in_frame_end, in_sample_index, r)) begin
        pending_results.push_back(table_fixed ? table_res : r);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_kind %0d verdict %0d sample_value %0h",
               out_result_kind, out_verdict, out_sample_value);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, out_result_kind);
          n_errors++;
        end
        if (out_verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_verdict);
          n_errors++;
        end
        if (out_sequence_res !== want.seq) begin
          $error("sequence_res: expected %0h, got %0h", want.seq, out_sequence_res);
          n_errors++;
        end
        if (out_sector !== want.sector) begin
          $error("sector: expected %0h, got %0h", want.sector, out_sector);
          n_errors++;
        end
        if (out_complete !== want.complete) begin
          $error("complete: expected %0d, got %0d", want.complete, out_complete);
          n_errors++;
        end
        if (out_sample_value !== want.value) begin
          $error("sample_value: expected %0h, got %0h", want.value, out_sample_value);
          n_errors++;
        end
      end
    end
  end

  task automatic put_item(input mode_t m, input logic [7:0] b, input logic fe,
                          input logic [12:0] idx, input logic fixed, input res_t want);
    // Step through the idling phases every 64 items.
    case ((n_sent / 64) % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
      default: begin src_idle_pct = 28; sink_stall_pct = 28; end
    endcase
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= m;
    in_data_byte    <= b;
    in_frame_end    <= fe;
    in_sample_index <= idx;
    table_fixed     <= fixed;
    table_res       <= want;
    n_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Read only from sectors already committed, or from past the end of the store.
  task automatic read_sample();
    int s;
    logic [12:0] idx;
    if (n_loaded == 0 || $urandom_range(6) == 0) begin
      idx = 13'($urandom_range(STORE_N, 8191));
    end else begin
      do s = $urandom_range(SECTORS - 1); while (!sector_loaded[s]);
      idx = 13'(s * SLOT_N + $urandom_range(SLOT_N - 1));
    end
    put_item(MODE_READ, 8'($urandom), 1'($urandom), idx, 1'b0, NO_RES);
  endtask

  task automatic send_frame(input logic [23:0] sync, input logic [7:0] seq_b,
                            input logic [15:0] sec, input int len, input logic good,
                            input logic fixed, input res_t want);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (i)
        0: b = sync[23:16];
        1: b = sync[15:8];
        2: b = sync[7:0];
        3: b = seq_b;
        4: b = sec[7:0];
        5: b = sec[15:8];
        default: b = 8'($urandom);
      endcase
      if (i > 0 && $urandom_range(99) < read_mix_pct) read_sample();
      put_item(MODE_BYTE, b, i == len - 1, 13'($urandom), fixed && i == len - 1, want);
    end
    if (good && !sector_loaded[sec[3:0]]) begin
      sector_loaded[sec[3:0]] = 1'b1;
      n_loaded++;
    end
  endtask

  task automatic begin_capture();
    cap_seq = 4'($urandom);
    foreach (cap_left[s]) cap_left[s] = 1'b1;
    n_left = SECTORS;
  endtask

  initial begin
    int pick;
    int s;
    int len;
    int sent_mark;
    logic [23:0] sync;
    logic [7:0]  seq_b;
    logic [15:0] sec;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(STEPS); i++) begin
      if (STEPS[i].op == MODE_READ)
        put_item(MODE_READ, 8'($urandom), 1'($urandom), STEPS[i].idx, STEPS[i].fixed,
                 STEPS[i].want);
      else
        send_frame(STEPS[i].sync, STEPS[i].seq_b, STEPS[i].sec, int'(STEPS[i].len),
                   STEPS[i].fixed && STEPS[i].want.verdict == VD_ACCEPT,
                   STEPS[i].fixed, STEPS[i].want);
    end

    // Random part: captures of well-formed frames, mixed with broken frames and reads.
    read_mix_pct = 1;
    begin_capture();
    sent_mark = n_sent;
    while (n_sent - sent_mark < 900) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        if ($urandom_range(9) == 0) s = $urandom_range(SECTORS - 1);
        else do s = $urandom_range(SECTORS - 1); while (!cap_left[s]);
        len = (s == SECTORS - 1 && $urandom_range(1) == 1) ? FRAME_LEN - 1 : FRAME_LEN;
        send_frame(SYNC_WORD, {4'($urandom), cap_seq}, 16'(s), len, 1'b1, 1'b0, NO_RES);
        if (cap_left[s]) begin
          cap_left[s] = 1'b0;
          n_left--;
        end
        if (n_left == 0) begin_capture();
      end else if (pick < 80) begin
        sync = SYNC_WORD;
        seq_b = 8'($urandom);
        sec = 16'($urandom_range(SECTORS - 1));
        len = ($urandom_range(5) == 0) ? FRAME_LEN : $urandom_range(HDR_LEN, 48);
        case ($urandom_range(5))
          0: sync[8 * $urandom_range(2) +: 8] ^= 8'($urandom_range(1, 255));
          1: len = $urandom_range(1, HDR_LEN - 1);
          2: sec = {MARKER_HI, 8'($urandom)};
          3: sec = 16'($urandom_range(SECTORS, 16'hFEFF));
          4: len = ($urandom_range(3) == 0) ? $urandom_range(FRAME_LEN + 1, 1100)
                                            : $urandom_range(HDR_LEN, FRAME_LEN - 2);
          default: begin
            sync = 24'($urandom);
            sec = 16'($urandom);
            len = $urandom_range(1, 30);
          end
        endcase
        send_frame(sync, seq_b, sec, len, 1'b0, 1'b0, NO_RES);
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 6)) read_sample();
      end else begin
        // Abandon the capture; a fresh sequence number, if it differs, clears the mask.
        begin_capture();
      end
    end

    in_valid <= 1'b0;
    sink_stall_pct = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0)
      $display("tb_sector_frame_reassembler: clean");
    else
      $display("tb_sector_frame_reassembler: errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_sector_frame_reassembler: errors");
    $finish;
  end

endmodule
